// ----- hdl/lwcm_pkg.sv -----
// ----------------------------------------------------------------------------
// Line word count and match package
// Shared constants, configuration register indexes and item codes for the
// line word counter and whole-word matcher.
// ----------------------------------------------------------------------------
package lwcm_pkg;

  // Widths fixed by the interface.
  localparam int CFG_DATA_BITS   = 64;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CHAR_BITS       = 8;
  localparam int WORD_COUNT_BITS = 10;
  localparam int TLEN_BITS       = 4;
  localparam int MAP_WORDS       = 4;
  localparam int MAP_WORD_BITS   = 64;
  localparam int TARGET_SLOTS    = 8;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_TARGET_BYTES = 8;
  localparam int DEF_COUNT_BITS       = 10;

  // Only the space character is a delimiter after reset.
  localparam logic [MAP_WORD_BITS-1:0] DELIM_LOW_RESET = 64'h0000_0001_0000_0000;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_DELIM_LOW      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DELIM_MID_LOW  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DELIM_MID_HIGH = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DELIM_HIGH     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_LENGTH  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_BYTES   = 3'd5;

  // Input word command codes.
  typedef enum logic {
    CMD_CHAR = 1'b0,
    CMD_EOL  = 1'b1
  } cmd_t;

endpackage

// ----- hdl/line_word_count_and_match_core.sv -----
// ----------------------------------------------------------------------------
// Line word count and match core
// Counts the delimiter-separated words of a text line and flags whether one
// of them equals a configured target word of up to eight bytes.
// ----------------------------------------------------------------------------
// The core takes one input word per clock cycle unless the input stalls.
// Each word is captured in an input register and processed from there by a
// bitmap lookup, one byte compare and the per-line flag updates. The result
// is held in an output register, so a new line may start while the previous
// result is still waiting to be taken; the input stalls only when an
// end-of-line word meets a result register that is full and itself stalled.
module line_word_count_and_match_core #(
  parameter int MAX_TARGET_BYTES = lwcm_pkg::DEF_MAX_TARGET_BYTES,
  parameter int COUNT_BITS       = lwcm_pkg::DEF_COUNT_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [lwcm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [lwcm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 cmd,
  input  logic [lwcm_pkg::CHAR_BITS-1:0]       ch,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [lwcm_pkg::WORD_COUNT_BITS-1:0] word_count,
  output logic                                 has_target
);
  import lwcm_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [TLEN_BITS-1:0]  MAX_TLEN  = TLEN_BITS'(MAX_TARGET_BYTES);

  // Configuration registers.
  logic [MAP_WORDS-1:0][MAP_WORD_BITS-1:0] delim_map;
  logic [TLEN_BITS-1:0]                    target_length;
  logic [TARGET_SLOTS-1:0][CHAR_BITS-1:0]  target_bytes;

  // Input register.
  logic                 s1_valid;
  logic                 s1_cmd;
  logic [CHAR_BITS-1:0] s1_ch;

  // Per-line state.
  logic [COUNT_BITS-1:0] words_seen, words_seen_next;
  logic                  inside_word, inside_word_next;
  logic [TLEN_BITS-1:0]  match_position, match_position_next;
  logic                  match_still_ok, match_still_ok_next;
  logic                  target_found, target_found_next;
  logic                  previous_was_delimiter, previous_was_delimiter_next;
  logic                  line_has_chars, line_has_chars_next;

  // Result register.
  logic [COUNT_BITS-1:0] res_count, res_count_next;
  logic                  has_target_next;

  logic                 in_accept;
  logic                 s1_go;
  logic                 s1_char;
  logic                 s1_eol;
  logic                 is_delim;
  logic [TLEN_BITS-1:0] eff_tlen;
  logic                 close_hit;
  logic [TLEN_BITS-1:0] pos_eff;
  logic                 ok_eff;
  logic [CHAR_BITS-1:0] target_byte;

  // Handshake: a character always moves on, an end of line needs room.
  assign s1_go     = (s1_cmd == CMD_CHAR) || !out_valid || !out_stall;
  assign in_stall  = s1_valid && !s1_go;
  assign in_accept = in_valid && !in_stall;
  assign s1_char   = s1_valid && (s1_cmd == CMD_CHAR);
  assign s1_eol    = s1_valid && (s1_cmd == CMD_EOL) && s1_go;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      delim_map     <= {{((MAP_WORDS-1)*MAP_WORD_BITS){1'b0}}, DELIM_LOW_RESET};
      target_length <= '0;
      target_bytes  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELIM_LOW:      delim_map[0]  <= cfg_data;
        REG_DELIM_MID_LOW:  delim_map[1]  <= cfg_data;
        REG_DELIM_MID_HIGH: delim_map[2]  <= cfg_data;
        REG_DELIM_HIGH:     delim_map[3]  <= cfg_data;
        REG_TARGET_LENGTH:  target_length <= cfg_data[TLEN_BITS-1:0];
        REG_TARGET_BYTES:   target_bytes  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept || (s1_valid && !s1_go);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd <= cmd;
      s1_ch  <= ch;
    end
  end

  // Target length is clipped to the number of stored bytes.
  assign eff_tlen = (target_length > MAX_TLEN) ? MAX_TLEN : target_length;

  // Delimiter lookup and the byte the current word is compared against.
  assign is_delim    = delim_map[s1_ch[7:6]][s1_ch[5:0]];
  assign pos_eff     = inside_word ? match_position : '0;
  assign ok_eff      = inside_word ? match_still_ok : 1'b1;
  assign target_byte = target_bytes[pos_eff[2:0]];

  // A word that closes matches when it consumed the whole non-empty target.
  assign close_hit = inside_word && match_still_ok && (eff_tlen != '0) &&
                     (match_position == eff_tlen);

  // Per-line state update.
  always_comb begin
    words_seen_next             = words_seen;
    inside_word_next            = inside_word;
    match_position_next         = match_position;
    match_still_ok_next         = match_still_ok;
    target_found_next           = target_found;
    previous_was_delimiter_next = previous_was_delimiter;
    line_has_chars_next         = line_has_chars;
    res_count_next              = words_seen;
    has_target_next             = target_found || close_hit ||
                                  ((eff_tlen == '0) && line_has_chars &&
                                   previous_was_delimiter);
    if (s1_char) begin
      line_has_chars_next = 1'b1;
      if (is_delim) begin
        target_found_next           = target_found || close_hit;
        inside_word_next            = 1'b0;
        match_still_ok_next         = 1'b0;
        match_position_next         = '0;
        previous_was_delimiter_next = 1'b1;
      end else begin
        previous_was_delimiter_next = 1'b0;
        inside_word_next            = 1'b1;
        if (!inside_word && (words_seen != COUNT_MAX)) begin
          words_seen_next = words_seen + 1'b1;
        end
        if (ok_eff && (pos_eff < eff_tlen) && (target_byte == s1_ch)) begin
          match_position_next = pos_eff + 1'b1;
          match_still_ok_next = 1'b1;
        end else begin
          match_position_next = pos_eff;
          match_still_ok_next = 1'b0;
        end
      end
    end else if (s1_eol) begin
      words_seen_next             = '0;
      inside_word_next            = 1'b0;
      match_position_next         = '0;
      match_still_ok_next         = 1'b0;
      target_found_next           = 1'b0;
      previous_was_delimiter_next = 1'b0;
      line_has_chars_next         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_seen             <= '0;
      inside_word            <= 1'b0;
      match_position         <= '0;
      match_still_ok         <= 1'b0;
      target_found           <= 1'b0;
      previous_was_delimiter <= 1'b0;
      line_has_chars         <= 1'b0;
    end else begin
      words_seen             <= words_seen_next;
      inside_word            <= inside_word_next;
      match_position         <= match_position_next;
      match_still_ok         <= match_still_ok_next;
      target_found           <= target_found_next;
      previous_was_delimiter <= previous_was_delimiter_next;
      line_has_chars         <= line_has_chars_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_eol) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_eol) begin
      res_count  <= res_count_next;
      has_target <= has_target_next;
    end
  end

  // The count field keeps the low bits of a wider count and zero-extends a narrower one.
  generate
    if (COUNT_BITS >= WORD_COUNT_BITS) begin : g_count_trunc
      assign word_count = res_count[WORD_COUNT_BITS-1:0];
    end else begin : g_count_ext
      assign word_count = {{(WORD_COUNT_BITS-COUNT_BITS){1'b0}}, res_count};
    end
  endgenerate

`ifndef SYNTHESIS
  // Outside a word no partial match may be pending.
  a_idle_match_clear: assert property (@(posedge clk) disable iff (rst)
    !inside_word |-> (match_position == '0) && !match_still_ok)
    else $error("match state left over outside a word");

  // The match position never runs past the stored target.
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    match_position <= MAX_TLEN)
    else $error("match position beyond target storage");

  // The input only stalls behind a held end of line.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && (s1_cmd == CMD_EOL) && out_valid)
    else $error("input stalled without a blocked end of line");

  // Ending a line produces a result and clears the line state.
  a_eol_result: assert property (@(posedge clk) disable iff (rst)
    s1_eol |=> out_valid && (words_seen == '0) && !target_found && !line_has_chars)
    else $error("end of line did not produce a result and clear state");
`endif

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// Line word count and match core testbench
// Sends text lines one character word at a time through the valid/stall
// input channel, with random gaps on both channels. A model of the core in
// this file works out the word count and target flag of every line, and each
// result taken from the core is compared with the oldest of those still due.
// A short scripted part is followed by random lines under random delimiter
// maps and target words, and by two lines long enough to saturate the count.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lwcm_pkg::*;

  localparam int TARGET_LIMIT   = DEF_MAX_TARGET_BYTES;
  localparam int COUNT_BITS     = DEF_COUNT_BITS;
  localparam int RANDOM_WORDS   = 1250;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_GAP        = 14;
  localparam int REPORT_LIMIT   = 10;
  localparam int DIRECTED_ROWS  = 30;
  localparam logic [CHAR_BITS-1:0] SPACE = 8'h20;

  typedef struct packed {
    logic [WORD_COUNT_BITS-1:0] count;
    logic                       hit;
  } line_tally_t;

  typedef enum logic {
    ROW_ITEM  = 1'b0,
    ROW_WRITE = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_INDEX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0]   data;
    cmd_t                       c;
    logic [CHAR_BITS-1:0]       chr;
    logic                       fixed;
    logic [WORD_COUNT_BITS-1:0] fixed_count;
    logic                       fixed_hit;
  } script_row_t;

  // Block ports.
  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic                       cmd       = CMD_CHAR;
  logic [CHAR_BITS-1:0]       ch        = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [WORD_COUNT_BITS-1:0] word_count;
  logic                       has_target;

  // Model copy of the configuration, starting from the reset values.
  logic [MAP_WORD_BITS-1:0] delim_map [MAP_WORDS] = '{DELIM_LOW_RESET, '0, '0, '0};
  logic [TLEN_BITS-1:0]     tgt_len   = '0;
  logic [CFG_DATA_BITS-1:0] tgt_bytes = '0;

  // Model copy of the per-line state.
  logic [COUNT_BITS-1:0] words_seen = '0;
  logic [TLEN_BITS-1:0]  match_pos  = '0;
  bit                    in_word    = 1'b0;
  bit                    match_ok   = 1'b0;
  bit                    found      = 1'b0;
  bit                    last_delim = 1'b0;
  bit                    has_chars  = 1'b0;

  line_tally_t awaited_tallies [$];

  bit calm = 1'b0;
  int words_sent     = 0;
  int lines_sent     = 0;
  int reg_writes     = 0;
  int results_seen   = 0;
  int mismatch_count = 0;
  int peak_count     = 0;
  int stall_left     = 0;

  // Scripted opening: reset behaviour, extremes of the bytes and the target.
  // Columns: kind, register, write data, cmd, ch, fixed result, count, flag.
  script_row_t directed_script [DIRECTED_ROWS] = '{
    // Empty line straight after reset.
    '{ROW_ITEM,  3'd0, 64'd0, CMD_EOL,  8'hA5, 1'b1, 10'd0, 1'b0},
    // A lone space with the empty target sets the flag.
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, SPACE, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_EOL,  8'h00, 1'b1, 10'd0, 1'b1},
    // Byte codes zero and 255 are ordinary characters by default.
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, 8'h00, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, 8'hFF, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, SPACE, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_EOL,  8'hFF, 1'b1, 10'd1, 1'b1},
    // Make zero and 255 delimiters too, target "cat" with junk above it.
    '{ROW_WRITE, REG_DELIM_LOW,     64'h0000_0001_0000_0001, CMD_CHAR, 8'h00,
      1'b0, 10'd0, 1'b0},
    '{ROW_WRITE, REG_DELIM_HIGH,    64'h8000_0000_0000_0000, CMD_CHAR, 8'h00,
      1'b0, 10'd0, 1'b0},
    '{ROW_WRITE, REG_TARGET_LENGTH, 64'h0000_0000_0000_0003, CMD_CHAR, 8'h00,
      1'b0, 10'd0, 1'b0},
    '{ROW_WRITE, REG_TARGET_BYTES,  64'hFFFF_FFFF_FF74_6163, CMD_CHAR, 8'h00,
      1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, 8'h63, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, 8'h61, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, 8'h74, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, 8'h00, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, 8'h63, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, 8'h61, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, 8'hFF, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_EOL,  8'h00, 1'b0, 10'd0, 1'b0},
    // Oversized length clamps to eight bytes: target "abcdefgh".
    '{ROW_WRITE, REG_TARGET_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF, CMD_CHAR, 8'h00,
      1'b0, 10'd0, 1'b0},
    '{ROW_WRITE, REG_TARGET_BYTES,  64'h6867_6665_6463_6261, CMD_CHAR, 8'h00,
      1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, 8'h61, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, 8'h62, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, 8'h63, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, 8'h64, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, 8'h65, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, 8'h66, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, 8'h67, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_CHAR, 8'h68, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM,  3'd0, 64'd0, CMD_EOL,  8'h5A, 1'b0, 10'd0, 1'b0}
  };

  line_word_count_and_match_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .ch         (ch),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_count (word_count),
    .has_target (has_target)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_delimiter(logic [CHAR_BITS-1:0] chr);
    return delim_map[chr[7:6]][chr[5:0]];
  endfunction

  // Target length as the core uses it, clamped to the slot count.
  function automatic int target_span();
    return (tgt_len > TARGET_LIMIT) ? TARGET_LIMIT : int'(tgt_len);
  endfunction

  // End the current text word, noting a whole-word match of a non-empty target.
  function automatic void close_text_word();
    if (in_word && match_ok && target_span() != 0 && match_pos == target_span())
      found = 1'b1;
    in_word   = 1'b0;
    match_ok  = 1'b0;
    match_pos = '0;
  endfunction

  // Advance the line state by one accepted word; an end of line yields a tally.
  function automatic bit tally_line_item(cmd_t c, logic [CHAR_BITS-1:0] chr,
                                         output line_tally_t tally);
    tally = '0;
    if (c == CMD_CHAR) begin
      has_chars = 1'b1;
      if (is_delimiter(chr)) begin
        close_text_word();
        last_delim = 1'b1;
      end else begin
        last_delim = 1'b0;
        if (!in_word) begin
          in_word   = 1'b1;
          match_pos = '0;
          match_ok  = 1'b1;
          if (words_seen != '1)
            words_seen = words_seen + 1'b1;
        end
        if (match_ok && match_pos < target_span() && tgt_bytes[8*match_pos +: 8] == chr)
          match_pos = match_pos + 1'b1;
        else
          match_ok = 1'b0;
      end
      return 1'b0;
    end
    close_text_word();
    // With an empty target, a non-empty line ending in a delimiter counts.
    if (target_span() == 0 && has_chars && last_delim)
      found = 1'b1;
    tally.count = words_seen[WORD_COUNT_BITS-1:0];
    tally.hit   = found;
    words_seen  = '0;
    in_word     = 1'b0;
    match_pos   = '0;
    match_ok    = 1'b0;
    found       = 1'b0;
    last_delim  = 1'b0;
    has_chars   = 1'b0;
    return 1'b1;
  endfunction

  // Random byte that is, or is not, a delimiter under the current map.
  function automatic logic [CHAR_BITS-1:0] pick_char(bit want_delim);
    logic [CHAR_BITS-1:0] chr;
    logic [CHAR_BITS-1:0] start;
    chr   = 8'($urandom_range(0, 255));
    start = chr;
    for (int k = 0; k < 256; k++) begin
      if (is_delimiter(start + 8'(k)) == want_delim)
        return start + 8'(k);
    end
    return chr;
  endfunction

  // Offer one word on the input channel after a random gap and wait for it.
  task automatic send_item(cmd_t c, logic [CHAR_BITS-1:0] chr,
                           bit use_fixed = 1'b0, line_tally_t fixed = '0);
    int          gap;
    line_tally_t tally;
    bit          taken;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    ch       <= chr;
    // The stall is settled by the falling edge and holds until the next rise.
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    words_sent++;
    if (tally_line_item(c, chr, tally)) begin
      awaited_tallies.push_back(use_fixed ? fixed : tally);
      lines_sent++;
    end
  endtask

  // Wait until every result has arrived and the pipeline has emptied.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (awaited_tallies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
    case (idx)
      REG_DELIM_LOW, REG_DELIM_MID_LOW, REG_DELIM_MID_HIGH, REG_DELIM_HIGH:
        delim_map[idx[1:0]] = data;
      REG_TARGET_LENGTH: tgt_len = data[TLEN_BITS-1:0];
      REG_TARGET_BYTES:  tgt_bytes = data;
      default: ;
    endcase
  endtask

  // New random settings; the spare indexes above the last register get writes too.
  task automatic reshuffle_config(bit every_reg);
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  v;
    for (int i = 0; i < 8; i++) begin
      idx = CFG_INDEX_BITS'(i);
      if (every_reg || $urandom_range(0, 2) == 0) begin
        v = {$urandom, $urandom};
        case (idx)
          REG_DELIM_LOW, REG_DELIM_MID_LOW, REG_DELIM_MID_HIGH, REG_DELIM_HIGH: begin
            case ($urandom_range(0, 5))
              0: v = '0;
              1: v = '1;
              2: v = v & {$urandom, $urandom} & {$urandom, $urandom};
              3: v = (idx == REG_DELIM_LOW) ? DELIM_LOW_RESET : '0;
              4: v = v | {$urandom, $urandom};
              default: ;
            endcase
          end
          REG_TARGET_LENGTH: begin
            case ($urandom_range(0, 5))
              0: v[TLEN_BITS-1:0] = '0;
              1: v[TLEN_BITS-1:0] = TLEN_BITS'($urandom_range(TARGET_LIMIT + 1, 15));
              default: v[TLEN_BITS-1:0] = TLEN_BITS'($urandom_range(1, TARGET_LIMIT));
            endcase
          end
          REG_TARGET_BYTES: begin
            // Mostly a small alphabet, so random text words hit the target.
            for (int j = 0; j < TARGET_SLOTS; j++)
              v[8*j +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(8'h61, 8'h64));
          end
          default: ;
        endcase
        write_reg(idx, v);
      end
    end
  endtask

  // One text word: the target, a near miss of it, or random letters.
  task automatic send_text_word();
    int                   span;
    int                   len;
    int                   flip_at;
    int                   style;
    logic [CHAR_BITS-1:0] chr;
    span    = target_span();
    style   = $urandom_range(0, 3);
    flip_at = -1;
    case (style)
      0: len = (span == 0) ? 1 : span;
      1: len = (span <= 1) ? 2 : span + ($urandom_range(0, 1) ? 1 : -1);
      2: begin
        len     = (span == 0) ? 1 : span;
        flip_at = $urandom_range(0, len - 1);
      end
      default: len = $urandom_range(1, 9);
    endcase
    for (int i = 0; i < len; i++) begin
      if (style != 3 && i < span)
        chr = tgt_bytes[8*i +: 8];
      else if ($urandom_range(0, 7) == 0)
        chr = 8'($urandom_range(0, 255));
      else
        chr = 8'($urandom_range(8'h61, 8'h64));
      if (i == flip_at)
        chr = chr ^ 8'($urandom_range(1, 255));
      send_item(CMD_CHAR, chr);
    end
  endtask

  // Stimulus.
  initial begin
    int          random_sent;
    int          phase_lines;
    int          calm_lines;
    int          text_words;
    bit          first_phase;
    line_tally_t fixed;
    random_sent = 0;
    phase_lines = 0;
    calm_lines  = 0;
    first_phase = 1'b1;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Scripted part.
    foreach (directed_script[r]) begin
      if (directed_script[r].kind == ROW_WRITE) begin
        settle_block();
        write_reg(directed_script[r].idx, directed_script[r].data);
      end else begin
        fixed.count = directed_script[r].fixed_count;
        fixed.hit   = directed_script[r].fixed_hit;
        send_item(directed_script[r].c, directed_script[r].chr,
                  directed_script[r].fixed, fixed);
      end
    end

    // Random lines, in phases of a few lines under one setting.
    while (random_sent < RANDOM_WORDS) begin
      if (phase_lines == 0) begin
        settle_block();
        reshuffle_config(first_phase);
        first_phase = 1'b0;
        phase_lines = $urandom_range(4, 12);
      end
      phase_lines--;
      if (calm_lines == 0 && $urandom_range(0, 5) == 0)
        calm_lines = $urandom_range(3, 10);
      calm = (calm_lines != 0);
      if (calm_lines != 0)
        calm_lines--;
      random_sent = random_sent - words_sent;
      if ($urandom_range(0, 9) == 0) begin
        // Noise: arbitrary bytes, sometimes none at all.
        repeat ($urandom_range(0, 12)) send_item(CMD_CHAR, 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 3) == 0)
          send_item(CMD_CHAR, pick_char(1'b1));
        text_words = $urandom_range(0, 6);
        for (int w = 0; w < text_words; w++) begin
          if (w != 0)
            repeat ($urandom_range(1, 2)) send_item(CMD_CHAR, pick_char(1'b1));
          send_text_word();
        end
        if ($urandom_range(0, 1))
          send_item(CMD_CHAR, pick_char(1'b1));
      end
      // The character byte of an end of line is ignored; drive it randomly.
      send_item(CMD_EOL, 8'($urandom_range(0, 255)));
      random_sent = random_sent + words_sent;
    end

    // Two lines that reach and pass the count ceiling, space separated.
    settle_block();
    write_reg(REG_DELIM_LOW, DELIM_LOW_RESET);
    calm = 1'b1;
    for (int k = 0; k < 2; k++) begin
      repeat (k == 0 ? (1 << COUNT_BITS) - 1 : (1 << COUNT_BITS) + 6) begin
        send_item(CMD_CHAR, pick_char(1'b0));
        send_item(CMD_CHAR, SPACE);
      end
      send_item(CMD_EOL, 8'h00);
    end

    settle_block();
    $display("Sent %0d input words forming %0d lines, with %0d register writes.",
             words_sent, lines_sent, reg_writes);
    $display("Compared %0d results; largest word count seen was %0d.",
             results_seen, peak_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result side: random stall before each result, compare in order.
  always @(posedge clk) begin
    line_tally_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (int'(word_count) > peak_count)
          peak_count = int'(word_count);
        if (awaited_tallies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected result word_count=%0d has_target=%0b",
                     $realtime, word_count, has_target);
        end else begin
          want = awaited_tallies.pop_front();
          if (word_count !== want.count || has_target !== want.hit) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: expected word_count=%0d has_target=%0b, got %0d %0b",
                       $realtime, want.count, want.hit, word_count, has_target);
          end
        end
        stall_left = calm ? 0 : $urandom_range(0, MAX_GAP);
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
